// ===== hw/rtl/hdst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdst_pkg
// Shared types and constants of the HID descriptor size tally.
// ----------------------------------------------------------------------------
package hdst_pkg;

  // Report ID table depth and its index width
  localparam int ID_ENTRIES = 256;
  localparam int IDX_W      = (ID_ENTRIES > 1) ? $clog2(ID_ENTRIES) : 1;

  // Descriptor encoding
  localparam logic [7:0] LONG_PREFIX  = 8'hFE;
  localparam logic [1:0] TYPE_MAIN    = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL  = 2'd1;
  localparam logic [1:0] CODE_FOUR    = 2'd3;
  localparam logic [3:0] TAG_INPUT    = 4'h8;
  localparam logic [3:0] TAG_OUTPUT   = 4'h9;
  localparam logic [3:0] TAG_FEATURE  = 4'hB;
  localparam logic [3:0] TAG_RPT_SIZE = 4'h7;
  localparam logic [3:0] TAG_RPT_ID   = 4'h8;
  localparam logic [3:0] TAG_RPT_CNT  = 4'h9;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_START = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_PREFIX    = 2'd0,
    PH_SHORT     = 2'd1,
    PH_LONG_SIZE = 2'd2,
    PH_LONG_SKIP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_INPUT   = 2'd0,
    KIND_OUTPUT  = 2'd1,
    KIND_FEATURE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] descriptor_byte;
    logic [7:0] query_id;
  } in_t;

  typedef struct packed {
    logic [7:0]  entry_id;
    logic [31:0] in_bit_cnt;
    logic [31:0] out_bit_cnt;
    logic [31:0] feat_bit_cnt;
    logic [28:0] in_byte_cnt;
    logic [28:0] out_byte_cnt;
    logic [28:0] feat_byte_cnt;
    logic        id_seen;
  } out_t;

  // One table entry: the three bit totals of a report ID
  typedef struct packed {
    logic [31:0] in_bits;
    logic [31:0] out_bits;
    logic [31:0] feat_bits;
  } tot_t;

  // Parser view handed to the table stage
  typedef struct packed {
    logic        add;
    kind_e       add_kind;
    logic [7:0]  cur_id;
    logic [31:0] field_size;
    logic [31:0] field_count;
    logic        seen;
  } parse_t;

  // Table request issued with an accepted transfer
  typedef struct packed {
    logic             is_read;
    logic             is_add;
    kind_e            kind;
    logic [IDX_W-1:0] addr;
    logic             in_range;
    logic [7:0]       entry_id;
    logic             seen;
    logic [31:0]      field_size;
    logic [31:0]      field_count;
  } req_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_read;
  } tbl_stat_t;

endpackage

// ===== hw/rtl/hid_descriptor_size_tally.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_descriptor_size_tally
// A read transfer's result is registered in stage 1, then in the output register.
// Throughput: one transfer per cycle (bytes, starts, reads) unless stage 1 holds a read behind a stalled output.
// The totals memory takes one read and one write per cycle; same-ID updates
// on consecutive cycles are forwarded, so there is no interlock bubble.
// Reset clears parser, globals and valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module hid_descriptor_size_tally (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hdst_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hdst_pkg::out_t out_data_o
);
  import hdst_pkg::*;

  // Stage 0: accept. Parser advances, the table memory is read.
  // Stage 1: read data back, total updated and written, or read result built.
  // Stage 2: output register.

  logic      accept;
  logic      op_byte, op_start, op_read;
  logic      s1_go;
  parse_t    parse;
  req_t      req;
  tbl_stat_t stat;
  out_t      res;
  logic [7:0] sel_id;

  logic out_valid_q;
  out_t out_q;

  always_comb begin
    op_byte  = 1'b0;
    op_start = 1'b0;
    op_read  = 1'b0;
    case (in_data_i.operation)
      OP_BYTE:  op_byte = 1'b1;
      OP_START: op_start = 1'b1;
      OP_READ:  op_read = 1'b1;
      default: ;  // unused code: transfer is taken and dropped
    endcase
  end

  // stage 1 only blocks when it holds a read and the output is full and stalled
  assign s1_go      = stat.s1_valid && (!stat.s1_read || !out_valid_q || !out_stall_i);
  assign in_stall_o = stat.s1_valid && !s1_go;
  assign accept     = in_valid_i && !in_stall_o;

  hdst_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (accept && op_byte),
    .clear_i   (accept && op_start),
    .byte_i    (in_data_i.descriptor_byte),
    .parse_o   (parse)
  );

  assign sel_id = op_read ? in_data_i.query_id : parse.cur_id;

  always_comb begin
    req.is_read     = op_read;
    req.in_range    = 32'(sel_id) < ID_ENTRIES;
    // IDs beyond the table drop their additions
    req.is_add      = op_byte && parse.add && req.in_range;
    req.kind        = parse.add_kind;
    req.addr        = IDX_W'(sel_id);
    req.entry_id    = in_data_i.query_id;
    req.seen        = parse.seen;
    req.field_size  = parse.field_size;
    req.field_count = parse.field_count;
  end

  hdst_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .start_i  (accept && op_start),
    .req_i    (req),
    .s1_go_i  (s1_go),
    .stat_o   (stat),
    .res_o    (res)
  );

  // output register parts stage 1 from the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && stat.s1_read) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && stat.s1_read) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/hdst_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdst_parser
// Byte-wise item parser; holds Report Size, Report Count, Report ID globals.
// ----------------------------------------------------------------------------
module hdst_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_en_i,
  input  logic            clear_i,
  input  logic [7:0]      byte_i,
  output hdst_pkg::parse_t parse_o
);
  import hdst_pkg::*;

  phase_e      phase_q, phase_d;
  logic [8:0]  left_q, left_d;
  logic [31:0] data_q, data_d;
  logic [5:0]  kind_q, kind_d;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] size_q, size_d;
  logic [31:0] count_q, count_d;
  logic [7:0]  id_q, id_d;
  logic        seen_q, seen_d;
  logic        add;
  kind_e       add_kind;
  logic [31:0] data_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      left_q  <= '0;
      data_q  <= '0;
      kind_q  <= '0;
      pos_q   <= '0;
      size_q  <= '0;
      count_q <= '0;
      id_q    <= '0;
      seen_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      data_q  <= data_d;
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      size_q  <= size_d;
      count_q <= count_d;
      id_q    <= id_d;
      seen_q  <= seen_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    data_d   = data_q;
    kind_d   = kind_q;
    pos_d    = pos_q;
    size_d   = size_q;
    count_d  = count_q;
    id_d     = id_q;
    seen_d   = seen_q;
    add      = 1'b0;
    add_kind = KIND_INPUT;
    data_new = data_q | (32'(byte_i) << {pos_q, 3'b000});

    if (clear_i) begin
      phase_d = PH_PREFIX;
      left_d  = '0;
      data_d  = '0;
      kind_d  = '0;
      pos_d   = '0;
      size_d  = '0;
      count_d = '0;
      id_d    = '0;
      seen_d  = 1'b0;
    end else if (byte_en_i) begin
      case (phase_q)
        PH_PREFIX: begin
          if (byte_i == LONG_PREFIX) begin
            phase_d = PH_LONG_SIZE;
          end else begin
            kind_d = byte_i[7:2];
            data_d = '0;
            pos_d  = '0;
            // globals restart from zero at their prefix
            if (byte_i[3:2] == TYPE_GLOBAL) begin
              case (byte_i[7:4])
                TAG_RPT_SIZE: size_d = '0;
                TAG_RPT_CNT:  count_d = '0;
                TAG_RPT_ID: begin
                  id_d   = '0;
                  seen_d = 1'b1;
                end
                default: ;
              endcase
            end
            // main items count at the prefix
            if (byte_i[3:2] == TYPE_MAIN) begin
              case (byte_i[7:4])
                TAG_INPUT: begin
                  add      = 1'b1;
                  add_kind = KIND_INPUT;
                end
                TAG_OUTPUT: begin
                  add      = 1'b1;
                  add_kind = KIND_OUTPUT;
                end
                TAG_FEATURE: begin
                  add      = 1'b1;
                  add_kind = KIND_FEATURE;
                end
                default: ;
              endcase
            end
            left_d  = (byte_i[1:0] == CODE_FOUR) ? 9'd4 : 9'(byte_i[1:0]);
            phase_d = (byte_i[1:0] != 2'd0) ? PH_SHORT : PH_PREFIX;
          end
        end
        PH_SHORT: begin
          data_d = data_new;
          pos_d  = pos_q + 2'd1;
          if (kind_q[1:0] == TYPE_GLOBAL) begin
            case (kind_q[5:2])
              TAG_RPT_SIZE: size_d = data_new;
              TAG_RPT_CNT:  count_d = data_new;
              TAG_RPT_ID:   id_d = data_new[7:0];
              default: ;
            endcase
          end
          left_d = left_q - 9'd1;
          if (left_q == 9'd1) begin
            phase_d = PH_PREFIX;
          end
        end
        PH_LONG_SIZE: begin
          // data bytes plus the tag byte
          left_d  = 9'(byte_i) + 9'd1;
          phase_d = PH_LONG_SKIP;
        end
        PH_LONG_SKIP: begin
          if (left_q != 9'd0) begin
            left_d = left_q - 9'd1;
          end
          if (left_q <= 9'd1) begin
            phase_d = PH_PREFIX;
          end
        end
        default: phase_d = PH_PREFIX;
      endcase
    end
  end

  assign parse_o.add         = add;
  assign parse_o.add_kind    = add_kind;
  assign parse_o.cur_id      = id_q;
  assign parse_o.field_size  = size_q;
  assign parse_o.field_count = count_q;
  assign parse_o.seen        = seen_q;

endmodule

// ===== hw/rtl/hdst_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdst_table
// Per-ID totals memory with valid bits and a read-modify-write stage.
// ----------------------------------------------------------------------------
module hdst_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                start_i,
  input  hdst_pkg::req_t      req_i,
  input  logic                s1_go_i,
  output hdst_pkg::tbl_stat_t stat_o,
  output hdst_pkg::out_t      res_o
);
  import hdst_pkg::*;

  tot_t tot_mem [ID_ENTRIES];
  tot_t rdata_q;

  logic [ID_ENTRIES-1:0] valid_q;

  logic             s1_valid_q;
  logic             s1_read_q;
  kind_e            s1_kind_q;
  logic [IDX_W-1:0] s1_addr_q;
  logic [31:0]      s1_prod_q;
  logic             s1_was_valid_q;
  logic             s1_fwd_q;
  tot_t             s1_fwd_data_q;
  logic [7:0]       s1_id_q;
  logic             s1_seen_q;

  logic rd_en;
  logic wr_en;
  tot_t base;
  tot_t wr_data;

  assign rd_en = accept_i && (req_i.is_read || req_i.is_add);
  assign wr_en = s1_go_i && s1_valid_q && !s1_read_q;

  // memory: read-before-write, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tot_mem[s1_addr_q] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= tot_mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (start_i) begin
      valid_q <= '0;
    end else if (accept_i && req_i.is_add) begin
      valid_q[req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || s1_go_i) begin
      s1_valid_q <= rd_en;
    end
  end

  // a write at the same edge as the read is not seen by the memory: forward it
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_read_q      <= req_i.is_read;
      s1_kind_q      <= req_i.kind;
      s1_addr_q      <= req_i.addr;
      s1_prod_q      <= 32'(req_i.field_size * req_i.field_count);
      s1_was_valid_q <= req_i.in_range && valid_q[req_i.addr];
      s1_fwd_q       <= wr_en && (s1_addr_q == req_i.addr);
      s1_fwd_data_q  <= wr_data;
      s1_id_q        <= req_i.entry_id;
      s1_seen_q      <= req_i.seen;
    end
  end

  always_comb begin
    if (!s1_was_valid_q) begin
      base = '0;
    end else if (s1_fwd_q) begin
      base = s1_fwd_data_q;
    end else begin
      base = rdata_q;
    end
    wr_data = base;
    case (s1_kind_q)
      KIND_INPUT:   wr_data.in_bits   = base.in_bits + s1_prod_q;
      KIND_OUTPUT:  wr_data.out_bits  = base.out_bits + s1_prod_q;
      KIND_FEATURE: wr_data.feat_bits = base.feat_bits + s1_prod_q;
      default: ;
    endcase
  end

  logic [31:0] in_rnd, out_rnd, feat_rnd;
  assign in_rnd   = base.in_bits + 32'd7;
  assign out_rnd  = base.out_bits + 32'd7;
  assign feat_rnd = base.feat_bits + 32'd7;

  assign res_o.entry_id      = s1_id_q;
  assign res_o.in_bit_cnt    = base.in_bits;
  assign res_o.out_bit_cnt   = base.out_bits;
  assign res_o.feat_bit_cnt  = base.feat_bits;
  assign res_o.in_byte_cnt   = in_rnd[31:3];
  assign res_o.out_byte_cnt  = out_rnd[31:3];
  assign res_o.feat_byte_cnt = feat_rnd[31:3];
  assign res_o.id_seen       = s1_seen_q;

  assign stat_o.s1_valid = s1_valid_q;
  assign stat_o.s1_read  = s1_read_q;

endmodule

// ===== hw/rtl/hdst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdst_checker
// Port-level checks of the size tally, bound to the top level.
// ----------------------------------------------------------------------------
module hdst_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input hdst_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input hdst_pkg::out_t out_data_o
);
  import hdst_pkg::*;

  // stalled input offer is held by the sender
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input offer changed");

  // stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // input side only backs up behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // byte counts follow the bit totals
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.in_byte_cnt == 29'((out_data_o.in_bit_cnt + 32'd7) >> 3) &&
      out_data_o.out_byte_cnt == 29'((out_data_o.out_bit_cnt + 32'd7) >> 3) &&
      out_data_o.feat_byte_cnt == 29'((out_data_o.feat_bit_cnt + 32'd7) >> 3))
    else $error("byte count does not match bit total");

endmodule

bind hid_descriptor_size_tally hdst_checker u_hdst_checker (.*);

// ===== tb/size_tally_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_tally_checker
// Watches both channels of the HID descriptor size tally, keeps its own copy
// of the parser, globals and per-ID totals, and compares every read result.
// ----------------------------------------------------------------------------
module size_tally_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  hdst_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  hdst_pkg::out_t out_data_i,
  output int             mismatches_o,
  output int             pending_reads_o
);
  import hdst_pkg::*;

  logic [31:0] in_tot   [ID_ENTRIES];
  logic [31:0] out_tot  [ID_ENTRIES];
  logic [31:0] feat_tot [ID_ENTRIES];
  bit          entry_live [ID_ENTRIES];

  logic [31:0] rpt_size;
  logic [31:0] rpt_count;
  logic [7:0]  rpt_id;
  bit          id_flag;
  phase_e      parse_phase;
  logic [8:0]  bytes_left;
  logic [31:0] item_value;
  logic [5:0]  item_kind;
  logic [1:0]  data_pos;

  out_t entry_reads_due[$];
  int   errors = 0;

  assign mismatches_o = errors;

  task automatic clear_tally();
    for (int i = 0; i < ID_ENTRIES; i++) begin
      entry_live[i] = 1'b0;
      in_tot[i]     = '0;
      out_tot[i]    = '0;
      feat_tot[i]   = '0;
    end
    rpt_size    = '0;
    rpt_count   = '0;
    rpt_id      = '0;
    id_flag     = 1'b0;
    parse_phase = PH_PREFIX;
    bytes_left  = '0;
    item_value  = '0;
    item_kind   = '0;
    data_pos    = '0;
  endtask

  // Globals follow the partial value, so a cut item keeps what arrived.
  task automatic latch_global();
    if (item_kind[1:0] == TYPE_GLOBAL) begin
      case (item_kind[5:2])
        TAG_RPT_SIZE: rpt_size  = item_value;
        TAG_RPT_CNT:  rpt_count = item_value;
        TAG_RPT_ID:   rpt_id    = item_value[7:0];
        default: ;
      endcase
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [3:0]  tag;
    logic [31:0] bits;
    tag  = b[7:4];
    bits = rpt_size * rpt_count;
    case (parse_phase)
      PH_PREFIX: begin
        if (b == LONG_PREFIX) begin
          parse_phase = PH_LONG_SIZE;
        end else begin
          item_kind  = b[7:2];
          item_value = '0;
          data_pos   = '0;
          if (b[3:2] == TYPE_GLOBAL && tag == TAG_RPT_ID) id_flag = 1'b1;
          latch_global();
          // main items count at the prefix; their data is ignored
          if (b[3:2] == TYPE_MAIN &&
              (tag == TAG_INPUT || tag == TAG_OUTPUT || tag == TAG_FEATURE) &&
              int'(rpt_id) < ID_ENTRIES) begin
            if (!entry_live[rpt_id]) begin
              in_tot[rpt_id]     = '0;
              out_tot[rpt_id]    = '0;
              feat_tot[rpt_id]   = '0;
              entry_live[rpt_id] = 1'b1;
            end
            case (tag)
              TAG_INPUT:  in_tot[rpt_id]   = in_tot[rpt_id] + bits;
              TAG_OUTPUT: out_tot[rpt_id]  = out_tot[rpt_id] + bits;
              default:    feat_tot[rpt_id] = feat_tot[rpt_id] + bits;
            endcase
          end
          bytes_left = (b[1:0] == CODE_FOUR) ? 9'd4 : {7'd0, b[1:0]};
          if (bytes_left != 0) parse_phase = PH_SHORT;
          else parse_phase = PH_PREFIX;
        end
      end
      PH_SHORT: begin
        item_value = item_value | (32'(b) << (8 * data_pos));
        data_pos   = data_pos + 2'd1;
        latch_global();
        bytes_left = bytes_left - 9'd1;
        if (bytes_left == 0) parse_phase = PH_PREFIX;
      end
      PH_LONG_SIZE: begin
        bytes_left  = {1'b0, b} + 9'd1;
        parse_phase = PH_LONG_SKIP;
      end
      default: begin
        if (bytes_left != 0) bytes_left = bytes_left - 9'd1;
        if (bytes_left == 0) parse_phase = PH_PREFIX;
      end
    endcase
  endtask

  function automatic out_t read_entry(input logic [7:0] q);
    out_t        r;
    logic [31:0] ib, ob, fb;
    ib = '0;
    ob = '0;
    fb = '0;
    if (int'(q) < ID_ENTRIES && entry_live[q]) begin
      ib = in_tot[q];
      ob = out_tot[q];
      fb = feat_tot[q];
    end
    r.entry_id      = q;
    r.in_bit_cnt    = ib;
    r.out_bit_cnt   = ob;
    r.feat_bit_cnt  = fb;
    r.in_byte_cnt   = 29'((ib + 32'd7) >> 3);
    r.out_byte_cnt  = 29'((ob + 32'd7) >> 3);
    r.feat_byte_cnt = 29'((fb + 32'd7) >> 3);
    r.id_seen       = id_flag;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      clear_tally();
      entry_reads_due.delete();
      pending_reads_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.operation)
          OP_BYTE:  parse_byte(in_data_i.descriptor_byte);
          OP_START: clear_tally();
          OP_READ:  entry_reads_due.push_back(read_entry(in_data_i.query_id));
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (entry_reads_due.size() == 0) begin
          $error("result transfer with no read outstanding");
          errors++;
        end else begin
          want = entry_reads_due.pop_front();
          check_field("entry_id", 32'(want.entry_id), 32'(out_data_i.entry_id));
          check_field("in_bit_cnt", want.in_bit_cnt, out_data_i.in_bit_cnt);
          check_field("out_bit_cnt", want.out_bit_cnt, out_data_i.out_bit_cnt);
          check_field("feat_bit_cnt", want.feat_bit_cnt, out_data_i.feat_bit_cnt);
          check_field("in_byte_cnt", 32'(want.in_byte_cnt),
                      32'(out_data_i.in_byte_cnt));
          check_field("out_byte_cnt", 32'(want.out_byte_cnt),
                      32'(out_data_i.out_byte_cnt));
          check_field("feat_byte_cnt", 32'(want.feat_byte_cnt),
                      32'(out_data_i.feat_byte_cnt));
          check_field("id_seen", 32'(want.id_seen), 32'(out_data_i.id_seen));
        end
      end
      pending_reads_o <= entry_reads_due.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the HID descriptor size tally: a directed run over
// the encoding corners, then random descriptors with reads mixed in, random
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import hdst_pkg::*;

  localparam int ITEM_TARGET    = 1400;  // counted transfers, ignored ops excluded
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 16;    // margin after the last read result

  // Unused operation code; the block must drop it without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Short item size codes below four bytes.
  localparam logic [1:0] CODE_NONE = 2'd0;
  localparam logic [1:0] CODE_ONE  = 2'd1;
  localparam logic [1:0] CODE_TWO  = 2'd2;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int mismatches;
  int pending_reads;

  int items_sent    = 0;
  bit no_idle       = 1'b0;  // both sides run back to back while set
  bit hold_off_req  = 1'b0;  // asks the result sink for one long stall

  hid_descriptor_size_tally dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  size_tally_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatches_o    (mismatches),
    .pending_reads_o (pending_reads)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Sender side. One transfer per call: an optional idle gap, then valid
  // stays up with a stable payload until the block takes it. With a zero gap
  // valid is never dropped between transfers.
  // --------------------------------------------------------------------------
  task automatic offer(input logic [1:0] op, input logic [7:0] b,
                       input logic [7:0] q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid                <= 1'b1;
    in_data.operation       <= op;
    in_data.descriptor_byte <= b;
    in_data.query_id        <= q;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Unused payload fields carry random bits so every input bit toggles.
  task automatic put_byte(input logic [7:0] b);
    offer(OP_BYTE, b, 8'($urandom));
  endtask

  task automatic put_start();
    offer(OP_START, 8'($urandom), 8'($urandom));
  endtask

  task automatic put_read(input logic [7:0] q);
    offer(OP_READ, 8'($urandom), q);
  endtask

  // Short item: prefix, then 0/1/2/4 data bytes, low byte first.
  task automatic emit_short(input logic [3:0] tag, input logic [1:0] itype,
                            input logic [1:0] code, input logic [31:0] value);
    int n;
    n = (code == CODE_FOUR) ? 4 : int'(code);
    put_byte({tag, itype, code});
    for (int k = 0; k < n; k++) put_byte(value[8*k +: 8]);
  endtask

  // Mostly a handful of IDs so reads land on live entries; now and then any.
  function automatic logic [7:0] pool_id();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 7));
  endfunction

  // Field sizes and counts: mostly small, sometimes full 32-bit for wrap.
  function automatic logic [31:0] field_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 40);
  endfunction

  // --------------------------------------------------------------------------
  // One random descriptor: start, a run of items with reads mixed in, then
  // reads of the usual IDs. Some descriptors are cut inside an item.
  // --------------------------------------------------------------------------
  task automatic random_descriptor();
    int          n_items, pick, len;
    logic [1:0]  code;
    logic [7:0]  prefix;
    logic [31:0] v;
    put_start();
    n_items = $urandom_range(3, 16);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      code = 2'($urandom_range(0, 3));
      if (pick < 14) begin
        v      = $urandom;
        v[7:0] = pool_id();
        emit_short(TAG_RPT_ID, TYPE_GLOBAL, code, v);
      end else if (pick < 28) begin
        emit_short(TAG_RPT_SIZE, TYPE_GLOBAL, code, field_value());
      end else if (pick < 42) begin
        emit_short(TAG_RPT_CNT, TYPE_GLOBAL, code, field_value());
      end else if (pick < 70) begin
        case ($urandom_range(0, 2))
          0:       emit_short(TAG_INPUT, TYPE_MAIN, code, $urandom);
          1:       emit_short(TAG_OUTPUT, TYPE_MAIN, code, $urandom);
          default: emit_short(TAG_FEATURE, TYPE_MAIN, code, $urandom);
        endcase
      end else if (pick < 78) begin
        // any other short item: local, reserved, push/pop and friends
        prefix = 8'($urandom);
        if (prefix == LONG_PREFIX) prefix = {TAG_RPT_SIZE, TYPE_MAIN, CODE_NONE};
        emit_short(prefix[7:4], prefix[3:2], prefix[1:0], $urandom);
      end else if (pick < 84) begin
        // long item: size byte, tag byte, then that many data bytes
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(0, 6);
        put_byte(LONG_PREFIX);
        put_byte(8'(len));
        put_byte(8'($urandom));
        repeat (len) put_byte(8'($urandom));
      end else if (pick < 95) begin
        put_read(pool_id());
      end else if (pick < 98) begin
        if ($urandom_range(0, 3) == 0) offer(OP_UNUSED, 8'($urandom), 8'($urandom));
        else put_read(pool_id());
      end else begin
        // cut short: a four-byte global stops after a few data bytes
        case ($urandom_range(0, 2))
          0:       put_byte({TAG_RPT_SIZE, TYPE_GLOBAL, CODE_FOUR});
          1:       put_byte({TAG_RPT_CNT, TYPE_GLOBAL, CODE_FOUR});
          default: put_byte({TAG_RPT_ID, TYPE_GLOBAL, CODE_FOUR});
        endcase
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
        repeat ($urandom_range(1, 3)) put_read(pool_id());
        return;
      end
    end
    repeat ($urandom_range(1, 4)) put_read(pool_id());
  endtask

  // --------------------------------------------------------------------------
  // Result sink. Random stall before each result transfer; one long hold-off
  // on request while the sender keeps pushing reads, so the block backs up.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold         = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int phase_no = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    put_start();
    put_read(8'h00);                                            // empty entry
    emit_short(TAG_RPT_SIZE, TYPE_GLOBAL, CODE_FOUR, 32'hFFFF_FFFF);
    emit_short(TAG_RPT_CNT, TYPE_GLOBAL, CODE_ONE, 32'h0000_0002);
    emit_short(TAG_RPT_ID, TYPE_GLOBAL, CODE_TWO, 32'h0000_01FF); // ID keeps low byte
    emit_short(TAG_INPUT, TYPE_MAIN, CODE_NONE, 32'h0);         // product wraps
    emit_short(TAG_FEATURE, TYPE_MAIN, CODE_ONE, 32'h0);        // counted at prefix
    put_byte(LONG_PREFIX);                                      // long item, one data byte
    put_byte(8'h01);
    put_byte(8'hAA);
    put_byte(8'h55);
    emit_short(TAG_OUTPUT, TYPE_MAIN, CODE_NONE, 32'h0);
    put_read(8'hFF);
    offer(OP_UNUSED, 8'h00, 8'h00);                             // dropped, no result
    put_byte({TAG_RPT_SIZE, TYPE_GLOBAL, CODE_FOUR});           // cut after one byte
    put_byte(8'h03);
    put_read(8'hFF);
    put_start();                                                // clears everything
    put_read(8'hFF);

    // ---- random ----
    while (items_sent < ITEM_TARGET) begin
      no_idle = (phase_no % 3 == 1);
      if (phase_no == 2) begin
        no_idle      = 1'b1;
        hold_off_req = 1'b1;
        repeat (40) put_read(pool_id());
      end else begin
        random_descriptor();
      end
      phase_no++;
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (pending_reads != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
